// ===== sv/aes128_block_encrypt_top_defines.svh =====
// Assertion macros shared by the AES-128 encryption block.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef AES128_BLOCK_ENCRYPT_TOP_DEFINES_SVH
`define AES128_BLOCK_ENCRYPT_TOP_DEFINES_SVH

// Overlapping implication checked on every rising clock edge outside reset.
`define AES_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error("aes128 assertion failed");

// Non-overlapping implication: the consequent is checked in the cycle after the antecedent.
`define AES_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> cons) \
    else $error("aes128 assertion failed");

`endif

// ===== sv/aes_pkg.sv =====
// Shared types, constants and byte functions of the AES-128 encryption block.
// Has no dependencies; used by the round cells and the top level.
package aes_pkg;

  localparam int unsigned NUM_ROUNDS = 10;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
  } plain_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } cipher_t;

  typedef struct packed {
    logic         valid;
    logic [127:0] state;
    logic [127:0] rkey;
  } stage_t;

  typedef enum logic [1:0] {
    CFG_KEY_HIGH = 2'd0,
    CFG_KEY_LOW  = 2'd1
  } cfg_idx_e;

  localparam logic [7:0] RCON [NUM_ROUNDS] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] sub_byte(input logic [7:0] b);
    return SBOX[b];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] mix_column(input logic [31:0] col);
    logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
    a0 = col[31:24];
    a1 = col[23:16];
    a2 = col[15:8];
    a3 = col[7:0];
    d0 = xtime(a0);
    d1 = xtime(a1);
    d2 = xtime(a2);
    d3 = xtime(a3);
    return {d0 ^ d1 ^ a1 ^ a2 ^ a3,
            a0 ^ d1 ^ d2 ^ a2 ^ a3,
            a0 ^ a1 ^ d2 ^ d3 ^ a3,
            d0 ^ a0 ^ a1 ^ a2 ^ d3};
  endfunction

endpackage

// ===== sv/aes_round_cell.sv =====
// One AES round cell: round transform and the matching key expansion step, registered.
// Depends on aes_pkg for the S-box, round constants and the stage type.
module aes_round_cell import aes_pkg::*; #(
  parameter int unsigned Round = 1
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  stage_t prev_i,
  output stage_t next_o
);

  localparam bit LastRound = (Round == NUM_ROUNDS);

  logic [127:0] shifted;
  logic [127:0] mixed;
  logic [31:0]  key_tmp;
  logic [127:0] rkey_d;
  logic [127:0] state_d;
  logic         valid_q;
  logic [127:0] state_q;
  logic [127:0] rkey_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        shifted[127 - 8 * (4 * c + r) -: 8] =
          sub_byte(prev_i.state[127 - 8 * (4 * ((c + r) & 3) + r) -: 8]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      if (LastRound) begin
        mixed[127 - 32 * c -: 32] = shifted[127 - 32 * c -: 32];
      end else begin
        mixed[127 - 32 * c -: 32] = mix_column(shifted[127 - 32 * c -: 32]);
      end
    end
    key_tmp = {sub_byte(prev_i.rkey[23:16]) ^ RCON[Round - 1],
               sub_byte(prev_i.rkey[15:8]),
               sub_byte(prev_i.rkey[7:0]),
               sub_byte(prev_i.rkey[31:24])};
    rkey_d[127:96] = prev_i.rkey[127:96] ^ key_tmp;
    rkey_d[95:64]  = prev_i.rkey[95:64] ^ rkey_d[127:96];
    rkey_d[63:32]  = prev_i.rkey[63:32] ^ rkey_d[95:64];
    rkey_d[31:0]   = prev_i.rkey[31:0] ^ rkey_d[63:32];
    state_d = mixed ^ rkey_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= prev_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
    rkey_q  <= rkey_d;
  end

  assign next_o = '{valid: valid_q, state: state_q, rkey: rkey_q};

endmodule

// ===== sv/aes128_block_encrypt_top.sv =====
// AES-128 block encryption: a row of ten round cells after a registered key-add stage.
// The start beat passes through the key-add register and then the ten round cells to done_o;
// one block is taken every cycle, and busy stays low.
// Each result shows for one cycle on done_o and cannot be held off by the receiver.
// Reset clears the pipeline valid bits and both key registers to zero.
// Depends on aes_pkg, aes_round_cell and aes128_block_encrypt_top_defines.svh.
`include "aes128_block_encrypt_top_defines.svh"

module aes128_block_encrypt_top import aes_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  plain_t      plain_i,
  output logic        done_o,
  output cipher_t     cipher_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  logic [63:0]  key_high_q;
  logic [63:0]  key_low_q;
  logic         entry_valid_q;
  logic [127:0] entry_state_q;
  logic [127:0] entry_rkey_q;
  stage_t       chain [NUM_ROUNDS + 1];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_KEY_HIGH: key_high_q <= cfg_data_i;
        CFG_KEY_LOW:  key_low_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= 1'b0;
    end else begin
      entry_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_state_q <= {plain_i.plain_high, plain_i.plain_low} ^ {key_high_q, key_low_q};
    entry_rkey_q  <= {key_high_q, key_low_q};
  end

  assign chain[0] = '{valid: entry_valid_q, state: entry_state_q, rkey: entry_rkey_q};

  for (genvar g = 1; g <= NUM_ROUNDS; g++) begin : g_round
    aes_round_cell #(
      .Round(g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .prev_i(chain[g - 1]),
      .next_o(chain[g])
    );
  end

  assign done_o   = chain[NUM_ROUNDS].valid;
  assign cipher_o = '{cipher_high: chain[NUM_ROUNDS].state[127:64],
                      cipher_low:  chain[NUM_ROUNDS].state[63:0]};

  `AES_ASSERT_IMPL(a_start_gives_done, start && !busy, ##11 done_o)
  `AES_ASSERT_IMPL(a_idle_gives_no_done, !start, ##11 !done_o)
  `AES_ASSERT_IMPL(a_done_has_start, done_o, $past(start, 11))
  `AES_ASSERT_NEXT(a_key_high_write, cfg_valid_i && cfg_ready_o && cfg_index_i == CFG_KEY_HIGH, key_high_q == $past(cfg_data_i))

endmodule
